>>> sv/csvft_pkg.sv
// csvft_pkg: shared constants and types of the csv field tokenizer
// holds field widths, limits, quote tracker codes and register indexes
// no dependencies
package csvft_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned RowW    = 16;
  localparam int unsigned ColW    = 10;
  localparam int unsigned LenW    = 8;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned OutDataW = 48;  // 43 bits of fields, padded to bytes

  // saturation limits
  localparam logic [LenW-1:0] MaxCellLen = 8'd255;
  localparam logic [RowW-1:0] MaxRow     = 16'd65535;
  localparam logic [ColW-1:0] MaxColumn  = 10'd1023;

  // special characters
  localparam logic [ByteW-1:0] ChrNul   = 8'd0;
  localparam logic [ByteW-1:0] ChrLf    = 8'd10;
  localparam logic [ByteW-1:0] ChrQuote = 8'd34;
  localparam logic [ByteW-1:0] ChrSpace = 8'd32;
  localparam logic [ByteW-1:0] ChrTab   = 8'd9;
  localparam logic [ByteW-1:0] ChrCr    = 8'd13;
  localparam logic [ByteW-1:0] ChrComma = 8'd44;

  // quote tracker codes
  localparam logic [1:0] QsStart   = 2'd0;
  localparam logic [1:0] QsInside  = 2'd1;
  localparam logic [1:0] QsOutside = 2'd2;

  // result kinds
  localparam logic KindContent = 1'b0;
  localparam logic KindCellEnd = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegSepA = 8'd0;
  localparam logic [CfgIdxW-1:0] RegSepB = 8'd1;
  localparam logic [CfgIdxW-1:0] RegSepC = 8'd2;
  localparam logic [CfgIdxW-1:0] RegSepD = 8'd3;

  // one result beat
  typedef struct packed {
    logic             item_kind;
    logic [ByteW-1:0] cell_byte;
    logic [RowW-1:0]  cell_row;
    logic [ColW-1:0]  cell_column;
    logic [LenW-1:0]  cell_length;
    logic             overflowed;
  } result_t;

endpackage

>>> sv/csv_field_tokenizer_unit.sv
// csv_field_tokenizer_unit: splits a byte stream into csv cells with coordinates
// depends on csvft_pkg
//
// channel  dir  handshake                    payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata[7:0] in_byte
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata cell fields, tuser item_kind
// cfg      in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// one byte per cycle while m_axis does not stall; a byte that yields a result passes through
// the input register, then quote and cell logic, into the result register and onto m_axis
// the tracker state updates as the byte leaves the input register
// reset clears tracker, length and both stage valids, sets row and column to 1; separator A
// resets to comma, B to D to NUL; a stall on m_axis holds the result register, then the input register, then s_axis
module csv_field_tokenizer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [csvft_pkg::ByteW-1:0]    s_axis_tdata,   // [7:0] in_byte
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] cell_byte, [23:8] cell_row, [33:24] cell_column,
  // [41:34] cell_length, [42] overflowed, [47:43] zero
  output logic [csvft_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                           m_axis_tuser,   // [0] item_kind
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [csvft_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [csvft_pkg::ByteW-1:0]    cfg_data_i
);
  import csvft_pkg::*;

  logic [ByteW-1:0] sep_a_q, sep_b_q, sep_c_q, sep_d_q;
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic [1:0]       quote_q, quote_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             drop_q, drop_d;
  logic             out_valid_q;
  result_t          out_q, res_d;
  logic             emit;
  logic             advance;
  logic             is_nl, is_ws, is_sep, is_quote, run_cell;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_a_q <= ChrComma;
      sep_b_q <= ChrNul;
      sep_c_q <= ChrNul;
      sep_d_q <= ChrNul;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegSepA: sep_a_q <= cfg_data_i;
        RegSepB: sep_b_q <= cfg_data_i;
        RegSepC: sep_c_q <= cfg_data_i;
        RegSepD: sep_d_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage handshake
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // byte classes
  always_comb begin
    is_nl    = (in_byte_q == ChrLf);
    is_quote = (in_byte_q == ChrQuote);
    is_ws    = (in_byte_q == ChrSpace) || (in_byte_q >= ChrTab && in_byte_q <= ChrCr);
    is_sep   = (in_byte_q == ChrNul)
            || (sep_a_q != ChrNul && in_byte_q == sep_a_q)
            || (sep_b_q != ChrNul && in_byte_q == sep_b_q)
            || (sep_c_q != ChrNul && in_byte_q == sep_c_q)
            || (sep_d_q != ChrNul && in_byte_q == sep_d_q);
  end

  // quote tracker and cell logic
  always_comb begin
    quote_d  = quote_q;
    row_d    = row_q;
    col_d    = col_q;
    len_d    = len_q;
    drop_d   = drop_q;
    run_cell = 1'b0;
    emit     = 1'b0;
    res_d.item_kind   = KindContent;
    res_d.cell_byte   = in_byte_q;
    res_d.cell_row    = row_q;
    res_d.cell_column = col_q;
    res_d.cell_length = len_q;
    res_d.overflowed  = 1'b0;

    if (is_nl) begin
      run_cell = 1'b1;
      quote_d  = QsStart;
    end else if (is_ws) begin
      run_cell = 1'b1;
    end else begin
      case (quote_q)
        QsInside: begin
          if (is_sep) begin
            run_cell = 1'b0;
          end else if (is_quote) begin
            quote_d = QsOutside;
          end else begin
            run_cell = 1'b1;
          end
        end
        QsOutside: begin
          if (is_sep) quote_d = QsStart;
          run_cell = 1'b1;
        end
        default: begin
          if (is_quote) begin
            quote_d = QsInside;
          end else if (is_sep) begin
            run_cell = 1'b1;
          end else begin
            run_cell = 1'b1;
            quote_d  = QsOutside;
          end
        end
      endcase
    end

    if (run_cell) begin
      if (is_nl || is_sep) begin
        // close the cell and move the coordinates
        if (len_q != '0) begin
          emit = 1'b1;
          res_d.item_kind  = KindCellEnd;
          res_d.cell_byte  = ChrNul;
          res_d.overflowed = drop_q;
        end
        len_d  = '0;
        drop_d = 1'b0;
        if (is_nl) begin
          if (row_q != MaxRow) row_d = row_q + RowW'(1);
          col_d = ColW'(1);
        end else if (col_q != MaxColumn) begin
          col_d = col_q + ColW'(1);
        end
      end else if (len_q != MaxCellLen) begin
        len_d = len_q + LenW'(1);
        emit  = 1'b1;
        res_d.cell_length = len_q + LenW'(1);
      end else begin
        drop_d = 1'b1;
      end
    end
  end

  // tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q <= QsStart;
      row_q   <= RowW'(1);
      col_q   <= ColW'(1);
      len_q   <= '0;
      drop_q  <= 1'b0;
    end else if (advance) begin
      quote_q <= quote_d;
      row_q   <= row_d;
      col_q   <= col_d;
      len_q   <= len_d;
      drop_q  <= drop_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.item_kind;
  assign m_axis_tdata  = {5'b0, out_q.overflowed, out_q.cell_length, out_q.cell_column,
                          out_q.cell_row, out_q.cell_byte};

  // checks on the tokenizer logic
  a_coord_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q != '0) && (col_q != '0))
    else $error("row or column counter reached zero");

  a_content_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KindContent) |->
      (out_q.cell_length != '0 && !out_q.overflowed))
    else $error("content beat with zero length or overflow flag");

  a_end_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KindCellEnd) |->
      (out_q.cell_byte == ChrNul && out_q.cell_length != '0))
    else $error("cell end beat with content byte or empty cell");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> (len_q == MaxCellLen))
    else $error("drop flag set below the length limit");

  a_nl_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_nl) |=> (col_q == ColW'(1) && quote_q == QsStart && len_q == '0))
    else $error("newline did not restart the row");

endmodule
